// ----- design/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared opcodes, cell commands and control structs for the cursor list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Fixed field widths of the item and result ports
  localparam int OPC_W      = 4;
  localparam int VAL_IN_W   = 32;
  localparam int POS_IN_W   = 10;
  localparam int CNT_OUT_W  = 11;

  // Widest cell index any legal capacity needs
  localparam int IDX_MAX_W  = 16;

  localparam logic [OPC_W-1:0] OP_QUERY      = 4'd0;
  localparam logic [OPC_W-1:0] OP_FIRST      = 4'd1;
  localparam logic [OPC_W-1:0] OP_LAST       = 4'd2;
  localparam logic [OPC_W-1:0] OP_SET_POS    = 4'd3;
  localparam logic [OPC_W-1:0] OP_PREV       = 4'd4;
  localparam logic [OPC_W-1:0] OP_NEXT       = 4'd5;
  localparam logic [OPC_W-1:0] OP_INS_BEFORE = 4'd6;
  localparam logic [OPC_W-1:0] OP_INS_AFTER  = 4'd7;
  localparam logic [OPC_W-1:0] OP_REMOVE     = 4'd8;
  localparam logic [OPC_W-1:0] OP_REPLACE    = 4'd9;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,   // cells above idx take left neighbor, cell idx takes new data
    CMD_REM,   // cells at or above idx take right neighbor
    CMD_WR     // cell idx takes new data
  } cle_cmd_e;

  typedef struct packed {
    cle_cmd_e               cmd;
    logic [IDX_MAX_W-1:0]   idx;
  } cle_cell_ctl_t;

  // Strobes for the two cursor readout stages
  typedef struct packed {
    logic                   grp_en;
    logic                   out_en;
    logic                   empty;
    logic [IDX_MAX_W-1:0]   idx;
  } cle_rd_ctl_t;

endpackage

// ----- design/cle_cell.sv -----
// ----------------------------------------------------------------------------
// cle_cell
// One list entry; shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module cle_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX       = 0
) (
  input  logic                     clk_i,
  input  cle_pkg::cle_cell_ctl_t   ctl_i,
  input  logic [VALUE_WIDTH-1:0]   wdata_i,
  input  logic [VALUE_WIDTH-1:0]   left_i,
  input  logic [VALUE_WIDTH-1:0]   right_i,
  output logic [VALUE_WIDTH-1:0]   value_o
);
  import cle_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

  logic [VALUE_WIDTH-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    case (ctl_i.cmd)
      CMD_INS: begin
        if (MY_IDX > ctl_i.idx) begin
          val_d = left_i;
        end else if (MY_IDX == ctl_i.idx) begin
          val_d = wdata_i;
        end
      end
      CMD_REM: begin
        if (MY_IDX >= ctl_i.idx) begin
          val_d = right_i;
        end
      end
      CMD_WR: begin
        if (MY_IDX == ctl_i.idx) begin
          val_d = wdata_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

// ----- design/cle_rdsel.sv -----
// ----------------------------------------------------------------------------
// cle_rdsel
// Two-stage registered select of the cursor entry out of the cell row.
// ----------------------------------------------------------------------------
module cle_rdsel #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  cle_pkg::cle_rd_ctl_t                  ctl_i,
  input  logic [VALUE_WIDTH-1:0]                cell_val_i [CAPACITY],
  output logic signed [cle_pkg::VAL_IN_W-1:0]   cursor_value_o
);
  import cle_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int LO_W = (IW + 1) / 2;
  localparam int HI_W = (IW - LO_W) > 0 ? (IW - LO_W) : 1;
  localparam int GS   = 2 ** LO_W;
  localparam int NG   = 2 ** HI_W;

  logic [IW:0]             idx_ext;
  logic [LO_W-1:0]         lo;
  logic [HI_W-1:0]         hi;
  logic [VALUE_WIDTH-1:0]  grp_in [NG][GS];
  logic [VALUE_WIDTH-1:0]  grp_q  [NG];
  logic [HI_W-1:0]         hi_q;
  logic                    empty_q;
  logic [VALUE_WIDTH-1:0]  sel_val;
  logic [63:0]             sel_ext;
  logic signed [VAL_IN_W-1:0] value_q;

  assign idx_ext = {1'b0, ctl_i.idx[IW-1:0]};
  assign lo      = idx_ext[LO_W-1:0];
  assign hi      = idx_ext[LO_W +: HI_W];

  // Pad the row up to NG groups of GS; slots past capacity read zero
  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar k = 0; k < GS; k++) begin : g_slot
      if (g * GS + k < CAPACITY) begin : g_live
        assign grp_in[g][k] = cell_val_i[g * GS + k];
      end else begin : g_pad
        assign grp_in[g][k] = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.grp_en) begin
        grp_q[g] <= grp_in[g][lo];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.grp_en) begin
      hi_q    <= hi;
      empty_q <= ctl_i.empty;
    end
  end

  assign sel_val = grp_q[hi_q];
  assign sel_ext = 64'(signed'(sel_val));

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_en) begin
      value_q <= empty_q ? '1 : signed'(sel_ext[VAL_IN_W-1:0]);
    end
  end

  assign cursor_value_o = value_q;

endmodule

// ----- design/cle_ctrl.sv -----
// ----------------------------------------------------------------------------
// cle_ctrl
// Cursor and count bookkeeping, cell command decode and result handshake.
// ----------------------------------------------------------------------------
module cle_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cle_pkg::OPC_W-1:0]             opcode_i,
  input  logic [cle_pkg::POS_IN_W-1:0]          position_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cle_pkg::CNT_OUT_W-1:0]  cursor_position_o,
  output logic [cle_pkg::CNT_OUT_W-1:0]         item_count_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o,
  output cle_pkg::cle_cell_ctl_t                cell_ctl_o,
  output cle_pkg::cle_rd_ctl_t                  rd_ctl_o
);
  import cle_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = CW > POS_IN_W ? CW : POS_IN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD1  = 2'd1;
  localparam logic [1:0] ST_RD2  = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [IW-1:0]  cursor_q, cursor_d;

  logic           accept, empty, full, pos_ok, at_last, can_next, out_free;
  logic [CW-1:0]  cnt_m1;
  logic [IW-1:0]  last_idx, cur_inc, cur_dec;
  logic [31:0]    cur32, cnt32;

  logic                        out_valid_q;
  logic signed [CNT_OUT_W-1:0] pos_q;
  logic [CNT_OUT_W-1:0]        cnt_q;
  logic                        empty_q, full_q;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(CAPACITY));
  assign cnt_m1   = count_q - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];
  assign cur_inc  = cursor_q + IW'(1);
  assign cur_dec  = cursor_q - IW'(1);
  assign pos_ok   = CMPW'(position_i) < CMPW'(count_q);
  assign at_last  = (CW'(cursor_q) == cnt_m1);
  assign can_next = (CW'(cursor_q) + CW'(1)) < count_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    cursor_d       = cursor_q;
    cell_ctl_o.cmd = CMD_HOLD;
    cell_ctl_o.idx = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD1;
          case (opcode_i)
            OP_FIRST: begin
              if (!empty) cursor_d = '0;
            end
            OP_LAST: begin
              if (!empty) cursor_d = last_idx;
            end
            OP_SET_POS: begin
              if (!empty && pos_ok) cursor_d = IW'(position_i);
            end
            OP_PREV: begin
              if (!empty && cursor_q != '0) cursor_d = cur_dec;
            end
            OP_NEXT: begin
              if (!empty && can_next) cursor_d = cur_inc;
            end
            OP_INS_BEFORE: begin
              if (!full) begin
                cell_ctl_o.cmd = CMD_INS;
                cell_ctl_o.idx = empty ? '0 : IDX_MAX_W'(cursor_q);
                count_d        = count_q + CW'(1);
                cursor_d       = empty ? '0 : cursor_q;
              end
            end
            OP_INS_AFTER: begin
              if (!full) begin
                cell_ctl_o.cmd = CMD_INS;
                cell_ctl_o.idx = empty ? '0 : IDX_MAX_W'(cur_inc);
                count_d        = count_q + CW'(1);
                cursor_d       = empty ? '0 : cur_inc;
              end
            end
            OP_REMOVE: begin
              if (!empty) begin
                cell_ctl_o.cmd = CMD_REM;
                cell_ctl_o.idx = IDX_MAX_W'(cursor_q);
                count_d        = cnt_m1;
                // tail removed: step back onto the new last entry
                if (at_last && cursor_q != '0) cursor_d = cur_dec;
              end
            end
            OP_REPLACE: begin
              if (!empty) begin
                cell_ctl_o.cmd = CMD_WR;
                cell_ctl_o.idx = IDX_MAX_W'(cursor_q);
              end
            end
            default: state_d = ST_RD1;
          endcase
        end
      end
      ST_RD1:  state_d = ST_RD2;
      ST_RD2: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if (rd_ctl_o.out_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rd_ctl_o.grp_en = (state_q == ST_RD1);
  assign rd_ctl_o.out_en = (state_q == ST_RD2) && out_free;
  assign rd_ctl_o.empty  = empty;
  assign rd_ctl_o.idx    = IDX_MAX_W'(cursor_q);

  assign cur32 = 32'(cursor_q);
  assign cnt32 = 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (rd_ctl_o.out_en) begin
      pos_q   <= empty ? '1 : signed'(cur32[CNT_OUT_W-1:0]);
      cnt_q   <= cnt32[CNT_OUT_W-1:0];
      empty_q <= empty;
      full_q  <= full;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = pos_q;
  assign item_count_o      = cnt_q;
  assign is_empty_o        = empty_q;
  assign is_full_o         = full_q;

  // Cursor always lands on a held entry
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> CW'(cursor_q) < count_q)
    else $error("cursor beyond last entry");

  a_cursor_zero_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> cursor_q == '0)
    else $error("cursor not zero on empty list");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count above capacity");

  a_count_frozen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |=> $stable(count_q) && $stable(cursor_q))
    else $error("list state moved during readout");

  a_one_result_per_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !rd_ctl_o.out_en ##1 rd_ctl_o.grp_en == 1'b0)
    else $error("readout sequence out of order");

endmodule

// ----- design/cursor_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// cursor_list_engine_core
// Bounded ordered list of signed values with a cursor, kept in a row of
// shifting cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | into core | in_valid_i/in_stall_o | opcode_i, value_i, position_i
//  out     | from core | out_valid_o/out_stall_i | cursor_value_o, cursor_position_o,
//          |           |                       | item_count_o, is_empty_o, is_full_o
//
//  Items: a new item is taken only once the previous result is loaded. The
//  row of cells shifts or writes at the edge that takes the input transfer,
//  then the cursor entry is picked out of the row by a two-stage registered
//  select (groups, then group) into the result register.
//  Reset: rst_ni clears count, cursor, state and the result valid; cell
//  contents stay undefined, no clearing pass.
//  Stalls: a held result blocks only the final select stage; the next input
//  transfer is taken as soon as that result has a free slot.
//
module cursor_list_engine_core #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // item channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cle_pkg::OPC_W-1:0]             opcode_i,
  input  logic signed [cle_pkg::VAL_IN_W-1:0]   value_i,
  input  logic [cle_pkg::POS_IN_W-1:0]          position_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cle_pkg::VAL_IN_W-1:0]   cursor_value_o,
  output logic signed [cle_pkg::CNT_OUT_W-1:0]  cursor_position_o,
  output logic [cle_pkg::CNT_OUT_W-1:0]         item_count_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o
);
  import cle_pkg::*;

  cle_cell_ctl_t           cell_ctl;
  cle_rd_ctl_t             rd_ctl;
  logic [VALUE_WIDTH-1:0]  cell_val [CAPACITY];
  logic [63:0]             value_ext;
  logic [VALUE_WIDTH-1:0]  wdata;

  // Stored form: sign-extend the 32-bit input, keep VALUE_WIDTH bits
  assign value_ext = 64'(value_i);
  assign wdata     = value_ext[VALUE_WIDTH-1:0];

  cle_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .position_i        (position_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_position_o (cursor_position_o),
    .item_count_o      (item_count_o),
    .is_empty_o        (is_empty_o),
    .is_full_o         (is_full_o),
    .cell_ctl_o        (cell_ctl),
    .rd_ctl_o          (rd_ctl)
  );

  // Row of cells; each one sees only its two neighbors and the broadcast
  // command. Ends of the row see zero; whatever shifts in there lies past
  // the last held entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left, right;

    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_left
      assign left = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_right
      assign right = cell_val[i+1];
    end

    cle_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .wdata_i (wdata),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[i])
    );
  end

  cle_rdsel #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_rdsel (
    .clk_i          (clk_i),
    .ctl_i          (rd_ctl),
    .cell_val_i     (cell_val),
    .cursor_value_o (cursor_value_o)
  );

endmodule

// ----- verif/tb_cursor_list_engine_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_list_engine_core
// Self-checking bench for the cursor list engine: a directed table of edge
// cases, then random operation streams that fill the list to capacity and
// drain it again; results are checked against a shadow list or fixed rows.
// ----------------------------------------------------------------------------
module tb_cursor_list_engine_core;
  import cle_pkg::*;

  // Geometry of the instance under test (default parameters)
  localparam int LIST_DEPTH   = 1024;
  localparam int POS_MAX      = (1 << POS_IN_W) - 1;
  localparam int ITEM_TOTAL   = 1900;
  localparam int MIXED_ITEMS  = 300;   // small-list random walk before the fill
  localparam int AT_FULL_OPS  = 80;    // items spent while the list sits at capacity
  localparam int CALM_FIRST   = 700;   // no idling on either side in this window
  localparam int CALM_LAST    = 1000;
  localparam int HOLD_AT      = 600;   // item index where the long result hold-off starts
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_CYC   = 20;
  localparam int IDLE_PCT     = 19;
  localparam time TIMEOUT_NS  = 2_000_000;

  // Opcodes the engine treats as a plain query
  localparam logic [OPC_W-1:0] OP_UNUSED_LO = 4'd10;
  localparam logic [OPC_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic signed [VAL_IN_W-1:0]  cval;
    logic signed [CNT_OUT_W-1:0] cpos;
    logic [CNT_OUT_W-1:0]        cnt;
    logic                        empty;
    logic                        full;
  } list_status_t;

  typedef struct {
    logic [OPC_W-1:0]           op;
    logic signed [VAL_IN_W-1:0] val;
    logic [POS_IN_W-1:0]        pos;
    bit                         typed;  // want holds a hand-written expectation
    list_status_t               want;
  } list_row_t;

  typedef enum {PH_MIXED, PH_FILL, PH_AT_FULL, PH_DRAIN} stim_phase_e;

  localparam list_status_t EMPTY_ST = '{cval: -32'sd1, cpos: -11'sd1, cnt: 11'd0,
                                        empty: 1'b1, full: 1'b0};

  // DUT ports
  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [OPC_W-1:0]            opcode_i;
  logic signed [VAL_IN_W-1:0]  value_i;
  logic [POS_IN_W-1:0]         position_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [VAL_IN_W-1:0]  cursor_value_o;
  logic signed [CNT_OUT_W-1:0] cursor_position_o;
  logic [CNT_OUT_W-1:0]        item_count_o;
  logic                        is_empty_o;
  logic                        is_full_o;

  // Shadow list state, advanced once per accepted input transfer
  logic signed [VAL_IN_W-1:0] shadow_list [LIST_DEPTH];
  int unsigned                shadow_count;
  int unsigned                shadow_cursor;

  list_status_t expected_status_q[$];
  list_row_t    directed_rows[$];

  // Cross-process controls: calm switches off random idling on both sides,
  // hold_req asks the result side for one long stall.
  bit calm;
  bit hold_req;

  int unsigned ops_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned peak_count;
  int unsigned rejected_inserts;
  int unsigned empty_noops;

  cursor_list_engine_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .value_i           (value_i),
    .position_i        (position_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_value_o    (cursor_value_o),
    .cursor_position_o (cursor_position_o),
    .item_count_o      (item_count_o),
    .is_empty_o        (is_empty_o),
    .is_full_o         (is_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // List operation predictor: applies one opcode to the shadow list and
  // returns the status the engine must report afterwards.
  // --------------------------------------------------------------------------
  function automatic list_status_t apply_list_op(input logic [OPC_W-1:0] op,
                                                 input logic signed [VAL_IN_W-1:0] val,
                                                 input logic [POS_IN_W-1:0] pos);
    list_status_t st;
    int unsigned  at;
    int unsigned  i;
    bit           was_empty;
    bit           was_full;
    was_empty = (shadow_count == 0);
    was_full  = (shadow_count >= LIST_DEPTH);
    if (was_empty && op inside {OP_FIRST, OP_LAST, OP_SET_POS, OP_PREV, OP_NEXT,
                                OP_REMOVE, OP_REPLACE})
      empty_noops++;
    case (op)
      OP_FIRST: begin
        if (!was_empty) shadow_cursor = 0;
      end
      OP_LAST: begin
        if (!was_empty) shadow_cursor = shadow_count - 1;
      end
      OP_SET_POS: begin
        if (pos < shadow_count) shadow_cursor = pos;
      end
      OP_PREV: begin
        if (!was_empty && shadow_cursor > 0) shadow_cursor--;
      end
      OP_NEXT: begin
        if (shadow_cursor + 1 < shadow_count) shadow_cursor++;
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (was_full) begin
          rejected_inserts++;
        end else begin
          // both inserts land at index 0 on an empty list
          if (was_empty) at = 0;
          else if (op == OP_INS_AFTER) at = shadow_cursor + 1;
          else at = shadow_cursor;
          for (i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = val;
          shadow_count++;
          shadow_cursor = at;
        end
      end
      OP_REMOVE: begin
        if (!was_empty) begin
          for (i = shadow_cursor; i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i+1];
          shadow_count--;
          // cursor moves to the follower, or back to the new tail
          if (shadow_count == 0) shadow_cursor = 0;
          else if (shadow_cursor >= shadow_count) shadow_cursor = shadow_count - 1;
        end
      end
      OP_REPLACE: begin
        if (!was_empty) shadow_list[shadow_cursor] = val;
      end
      default: ;  // query and the unused opcodes change nothing
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    if (shadow_count == 0) begin
      st.cval = -32'sd1;
      st.cpos = -11'sd1;
    end else begin
      st.cval = shadow_list[shadow_cursor];
      st.cpos = CNT_OUT_W'(shadow_cursor);
    end
    st.cnt   = CNT_OUT_W'(shadow_count);
    st.empty = (shadow_count == 0);
    st.full  = (shadow_count >= LIST_DEPTH);
    return st;
  endfunction

  function automatic logic [OPC_W-1:0] pick_opcode(input stim_phase_e ph);
    int unsigned r;
    int unsigned ins_lim;
    int unsigned rem_lim;
    int unsigned rep_lim;
    int unsigned unu_lim;
    case (ph)
      PH_MIXED:   begin ins_lim = 26; rem_lim = 52; rep_lim = 60; unu_lim = 64; end
      PH_FILL:    begin ins_lim = 85; rem_lim = 88; rep_lim = 91; unu_lim = 93; end
      PH_AT_FULL: begin ins_lim = 40; rem_lim = 42; rep_lim = 50; unu_lim = 54; end
      default:    begin ins_lim = 15; rem_lim = 70; rep_lim = 76; unu_lim = 80; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_lim) return ($urandom_range(0, 1) != 0) ? OP_INS_AFTER : OP_INS_BEFORE;
    if (r < rem_lim) return OP_REMOVE;
    if (r < rep_lim) return OP_REPLACE;
    if (r < unu_lim) return OPC_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    case ($urandom_range(0, 5))
      0:       return OP_QUERY;
      1:       return OP_FIRST;
      2:       return OP_LAST;
      3:       return OP_SET_POS;
      4:       return OP_PREV;
      default: return OP_NEXT;
    endcase
  endfunction

  function automatic logic signed [VAL_IN_W-1:0] pick_value();
    if ($urandom_range(0, 99) >= 10) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic add_row(input logic [OPC_W-1:0] op, input logic signed [VAL_IN_W-1:0] val,
                         input logic [POS_IN_W-1:0] pos, input bit typed,
                         input list_status_t want);
    list_row_t row;
    row.op = op; row.val = val; row.pos = pos; row.typed = typed; row.want = want;
    directed_rows.push_back(row);
  endtask

  // Offer one item and hold it until the engine takes the transfer.
  task automatic send_op(input logic [OPC_W-1:0] op, input logic signed [VAL_IN_W-1:0] val,
                         input logic [POS_IN_W-1:0] pos, input bit typed,
                         input list_status_t want);
    list_status_t predicted;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_list_op(op, val, pos);
    expected_status_q.push_back(typed ? want : predicted);
    ops_sent++;
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Item side: directed table first, then the random phases.
  // --------------------------------------------------------------------------
  initial begin
    stim_phase_e            phase;
    int unsigned            n;
    int unsigned            full_ops;
    logic [OPC_W-1:0]       op;
    logic [POS_IN_W-1:0]    pos;
    in_valid_i       = 1'b0;
    opcode_i         = OP_QUERY;
    value_i          = '0;
    position_i       = '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    shadow_count     = 0;
    shadow_cursor    = 0;
    ops_sent         = 0;
    peak_count       = 0;
    rejected_inserts = 0;
    empty_noops      = 0;

    // Each defined opcode but the inserts, on the empty list right after reset: nothing moves.
    add_row(OP_QUERY,      0, 0, 1, EMPTY_ST);
    add_row(OP_FIRST,      0, 0, 1, EMPTY_ST);
    add_row(OP_LAST,       0, 0, 1, EMPTY_ST);
    add_row(OP_SET_POS,    0, 0, 1, EMPTY_ST);
    add_row(OP_PREV,       0, 0, 1, EMPTY_ST);
    add_row(OP_NEXT,       0, 0, 1, EMPTY_ST);
    add_row(OP_REMOVE,     0, 0, 1, EMPTY_ST);
    add_row(OP_REPLACE,    32'sh1234_5678, 0, 1, EMPTY_ST);
    // Insert after on empty lands at index 0; insert before keeps index 0.
    add_row(OP_INS_AFTER,  32'sh7FFF_FFFF, 0, 1,
            '{cval: 32'sh7FFF_FFFF, cpos: 11'sd0, cnt: 11'd1, empty: 1'b0, full: 1'b0});
    add_row(OP_INS_BEFORE, 32'sh8000_0000, 0, 1,
            '{cval: 32'sh8000_0000, cpos: 11'sd0, cnt: 11'd2, empty: 1'b0, full: 1'b0});
    add_row(OP_INS_AFTER,  -32'sd1, 0, 0, '0);
    // Navigation up to and past both ends
    add_row(OP_PREV,       0, 0, 0, '0);
    add_row(OP_PREV,       0, 0, 0, '0);
    add_row(OP_NEXT,       0, 0, 0, '0);
    add_row(OP_NEXT,       0, 0, 0, '0);
    add_row(OP_NEXT,       0, 0, 0, '0);
    add_row(OP_SET_POS,    0, POS_IN_W'(POS_MAX), 0, '0);  // beyond count: ignored
    add_row(OP_SET_POS,    0, 1, 0, '0);
    add_row(OP_REPLACE,    0, 0, 0, '0);
    // Remove the tail, then the head, then the last entry
    add_row(OP_LAST,       0, 0, 0, '0);
    add_row(OP_REMOVE,     0, 0, 0, '0);
    add_row(OP_FIRST,      0, 0, 0, '0);
    add_row(OP_REMOVE,     0, 0, 0, '0);
    add_row(OP_UNUSED_HI,  0, 0, 0, '0);
    add_row(OP_REMOVE,     0, 0, 1, EMPTY_ST);

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      maybe_pause();
      send_op(directed_rows[k].op, directed_rows[k].val, directed_rows[k].pos,
              directed_rows[k].typed, directed_rows[k].want);
    end

    // Random part. The fill phase runs until the list reaches capacity, so the
    // item budget is extended if the walk happens to be slow.
    phase    = PH_MIXED;
    full_ops = 0;
    n        = 0;
    while (n < ITEM_TOTAL || phase == PH_FILL) begin
      if (phase == PH_MIXED && n == MIXED_ITEMS) begin
        // Sender pause: let every outstanding result drain first.
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_status_q.size() != 0);
        phase = PH_FILL;
      end else if (phase == PH_FILL && shadow_count >= LIST_DEPTH) begin
        phase = PH_AT_FULL;
      end else if (phase == PH_AT_FULL && full_ops == AT_FULL_OPS) begin
        phase = PH_DRAIN;
      end
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n == HOLD_AT) hold_req = 1'b1;  // result side stalls; we keep offering

      op = pick_opcode(phase);
      if (op == OP_SET_POS && shadow_count > 0 && $urandom_range(0, 99) < 70)
        pos = POS_IN_W'($urandom_range(0, shadow_count - 1));
      else
        pos = POS_IN_W'($urandom_range(0, POS_MAX));
      maybe_pause();
      send_op(op, pick_value(), pos, 0, '0);
      if (phase == PH_AT_FULL) full_ops++;
      n++;
    end

    in_valid_i <= 1'b0;
    calm = 1'b0;
    do @(posedge clk_i); while (expected_status_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Ran %0d list operations, %0d results compared; list peaked at %0d of %0d",
             ops_sent, results_checked, peak_count, LIST_DEPTH);
    $display("Inserts refused on a full list: %0d, operations ignored on an empty list: %0d",
             rejected_inserts, empty_noops);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request so the
  // engine backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Result checker: each result transfer against the oldest expectation.
  initial begin
    list_status_t want;
    results_checked = 0;
    mismatch_count  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          $error("result transfer with no operation outstanding");
          mismatch_count++;
        end else begin
          want = expected_status_q.pop_front();
          results_checked++;
          if (cursor_value_o !== want.cval) begin
            $error("cursor_value: expected %0d, got %0d", want.cval, cursor_value_o);
            mismatch_count++;
          end
          if (cursor_position_o !== want.cpos) begin
            $error("cursor_position: expected %0d, got %0d", want.cpos, cursor_position_o);
            mismatch_count++;
          end
          if (item_count_o !== want.cnt) begin
            $error("item_count: expected %0d, got %0d", want.cnt, item_count_o);
            mismatch_count++;
          end
          if (is_empty_o !== want.empty) begin
            $error("is_empty: expected %0b, got %0b", want.empty, is_empty_o);
            mismatch_count++;
          end
          if (is_full_o !== want.full) begin
            $error("is_full: expected %0b, got %0b", want.full, is_full_o);
            mismatch_count++;
          end
        end
      end
    end
  end

endmodule

// ----- files.f -----
design/cle_pkg.sv
design/cle_cell.sv
design/cle_rdsel.sv
design/cle_ctrl.sv
design/cursor_list_engine_core.sv
verif/tb_cursor_list_engine_core.sv
